/* sv/pcomp_pkg.sv */
// Shared types and constants for the pressure sensor compensation pipeline.
package pcomp_pkg;

    typedef enum logic [2:0] {
        REG_PRESSURE_SENS   = 3'd0,
        REG_PRESSURE_OFFSET = 3'd1,
        REG_SENS_TEMP_COEFF = 3'd2,
        REG_OFFS_TEMP_COEFF = 3'd3,
        REG_REF_TEMP        = 3'd4,
        REG_TEMP_SLOPE      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } t_cal;

    localparam logic signed [18:0] TEMP_REF      = 19'sd2000;
    localparam logic signed [18:0] TEMP_VLOW_LIM = -19'sd1599;
    localparam logic signed [18:0] TEMP_VLOW_OFS = 19'sd1500;

    localparam logic signed [19:0] TEMP_OUT_MAX = 20'sd262143;
    localparam logic signed [19:0] TEMP_OUT_MIN = -20'sd262144;

    // x / 8192 / 10 limits, applied before the divide
    localparam logic signed [42:0] X_NEG_LIM = -43'sd81920;
    localparam logic signed [42:0] X_POS_LIM = 43'sd5368709120;

    // q / 10 == (q * DIV10_MUL) >> 23 for q < 2^22
    localparam logic [19:0] DIV10_MUL = 20'd838861;

endpackage

/* sv/pcomp_first.sv */
// First-order stages: dT, calibration products, TEMP, OFF, SENS and T2 candidates.
module pcomp_first (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [23:0]         i_raw_pressure,
    input  logic [23:0]         i_raw_temperature,
    input  pcomp_pkg::t_cal     i_cal,
    output logic                o_valid,
    output logic [23:0]         o_d1,
    output logic signed [18:0]  o_temp1,
    output logic signed [17:0]  o_tq,
    output logic signed [33:0]  o_sens1,
    output logic signed [34:0]  o_off1,
    output logic [16:0]         o_ti_lo,
    output logic [11:0]         o_ti_hi
);
    import pcomp_pkg::*;

    // stage A
    logic signed [24:0] n_dt, r_dt;
    logic [23:0]        r_d1a;
    logic               r_va;

    // stage B
    logic signed [16:0] w_c6s, w_c3s, w_c4s;
    logic signed [40:0] n_m6, n_m3, n_m4, r_m6, r_m3, r_m4;
    logic signed [48:0] w_sq_full;
    logic [47:0]        n_sq, r_sq;
    logic [23:0]        r_d1b;
    logic               r_vb;

    // stage C
    logic signed [40:0] w_m6b, w_m3b, w_m4b;
    logic signed [17:0] w_q6;
    logic signed [32:0] w_q3;
    logic signed [33:0] w_q4;
    logic [49:0]        w_sq3;
    logic signed [18:0] n_temp1, r_temp1;
    logic signed [33:0] n_sens1, r_sens1;
    logic signed [34:0] n_off1, r_off1;
    logic signed [17:0] r_tq;
    logic [16:0]        r_ti_lo;
    logic [11:0]        r_ti_hi;
    logic [23:0]        r_d1c;
    logic               r_vc;

    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.c5, 8'b0});

    assign w_c6s     = $signed({1'b0, i_cal.c6});
    assign w_c3s     = $signed({1'b0, i_cal.c3});
    assign w_c4s     = $signed({1'b0, i_cal.c4});
    assign n_m6      = 41'(w_c6s * r_dt);
    assign n_m3      = 41'(w_c3s * r_dt);
    assign n_m4      = 41'(w_c4s * r_dt);
    assign w_sq_full = 49'(r_dt * r_dt);
    assign n_sq      = w_sq_full[47:0];

    // truncating divides: bias negatives by divisor - 1
    assign w_m6b = r_m6 + (r_m6[40] ? 41'sd8388607 : 41'sd0);
    assign w_m3b = r_m3 + (r_m3[40] ? 41'sd255 : 41'sd0);
    assign w_m4b = r_m4 + (r_m4[40] ? 41'sd127 : 41'sd0);
    assign w_q6  = w_m6b[40:23];
    assign w_q3  = w_m3b[40:8];
    assign w_q4  = w_m4b[40:7];

    assign n_temp1 = TEMP_REF + 19'(w_q6);
    assign n_sens1 = 34'($signed({1'b0, i_cal.c1, 15'b0})) + 34'(w_q3);
    assign n_off1  = 35'($signed({1'b0, i_cal.c2, 16'b0})) + 35'(w_q4);
    assign w_sq3   = {2'b0, r_sq} + {1'b0, r_sq, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dt    <= n_dt;
            r_d1a   <= i_raw_pressure;
            r_m6    <= n_m6;
            r_m3    <= n_m3;
            r_m4    <= n_m4;
            r_sq    <= n_sq;
            r_d1b   <= r_d1a;
            r_temp1 <= n_temp1;
            r_tq    <= w_q6;
            r_sens1 <= n_sens1;
            r_off1  <= n_off1;
            r_ti_lo <= w_sq3[49:33];
            r_ti_hi <= r_sq[47:36];
            r_d1c   <= r_d1b;
        end
    end

    assign o_valid = r_vc;
    assign o_d1    = r_d1c;
    assign o_temp1 = r_temp1;
    assign o_tq    = r_tq;
    assign o_sens1 = r_sens1;
    assign o_off1  = r_off1;
    assign o_ti_lo = r_ti_lo;
    assign o_ti_hi = r_ti_hi;

endmodule

/* sv/pcomp_second.sv */
// Second-order correction stages: band select, squares, OFFi/SENSi and corrected terms.
module pcomp_second (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [23:0]         i_d1,
    input  logic signed [18:0]  i_temp1,
    input  logic signed [17:0]  i_tq,
    input  logic signed [33:0]  i_sens1,
    input  logic signed [34:0]  i_off1,
    input  logic [16:0]         i_ti_lo,
    input  logic [11:0]         i_ti_hi,
    output logic                o_valid,
    output logic [23:0]         o_d1,
    output logic signed [19:0]  o_temp2,
    output logic signed [38:0]  o_sens2,
    output logic signed [39:0]  o_off2
);
    import pcomp_pkg::*;

    // stage D
    logic               w_lo, w_vlo;
    logic signed [18:0] w_u;
    logic signed [17:0] w_um;
    logic signed [35:0] w_tsq_full, w_usq_full;
    logic [16:0]        w_ti;
    logic signed [19:0] n_temp2;
    logic [33:0]        r_tsq, r_usq;
    logic signed [19:0] r_temp2d;
    logic signed [33:0] r_sens1d;
    logic signed [34:0] r_off1d;
    logic [23:0]        r_d1d;
    logic               r_lo, r_vd;

    // stage E
    logic [35:0]        w_t3;
    logic [36:0]        w_u7, w_t5;
    logic [37:0]        n_offi, r_offi;
    logic [36:0]        n_sensi, r_sensi;
    logic signed [19:0] r_temp2e;
    logic signed [33:0] r_sens1e;
    logic signed [34:0] r_off1e;
    logic [23:0]        r_d1e;
    logic               r_ve;

    // stage F
    logic signed [39:0] n_off2, r_off2;
    logic signed [38:0] n_sens2, r_sens2;
    logic signed [19:0] r_temp2f;
    logic [23:0]        r_d1f;
    logic               r_vf;

    assign w_lo       = i_temp1 < TEMP_REF;
    assign w_vlo      = i_temp1 < TEMP_VLOW_LIM;
    assign w_u        = i_temp1 + TEMP_VLOW_OFS;
    assign w_um       = w_vlo ? w_u[17:0] : '0;
    assign w_tsq_full = 36'(i_tq * i_tq);
    assign w_usq_full = 36'(w_um * w_um);
    assign w_ti       = w_lo ? i_ti_lo : {5'b0, i_ti_hi};
    assign n_temp2    = 20'(i_temp1) - 20'($signed({1'b0, w_ti}));

    assign w_t3    = {2'b0, r_tsq} + {1'b0, r_tsq, 1'b0};
    assign w_u7    = {r_usq, 3'b0} - {3'b0, r_usq};
    assign w_t5    = {3'b0, r_tsq} + {1'b0, r_tsq, 2'b0};
    assign n_offi  = r_lo ? (38'(w_t3[35:1]) + 38'(w_u7)) : 38'(r_tsq[33:4]);
    assign n_sensi = r_lo ? (37'(w_t5[36:3]) + 37'({r_usq, 2'b0})) : '0;

    assign n_off2  = 40'(r_off1e) - 40'($signed({1'b0, r_offi}));
    assign n_sens2 = 39'(r_sens1e) - $signed({2'b0, r_sensi});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else if (i_en) begin
            r_vd <= i_valid;
            r_ve <= r_vd;
            r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tsq    <= w_tsq_full[33:0];
            r_usq    <= w_usq_full[33:0];
            r_temp2d <= n_temp2;
            r_sens1d <= i_sens1;
            r_off1d  <= i_off1;
            r_d1d    <= i_d1;
            r_lo     <= w_lo;
            r_offi   <= n_offi;
            r_sensi  <= n_sensi;
            r_temp2e <= r_temp2d;
            r_sens1e <= r_sens1d;
            r_off1e  <= r_off1d;
            r_d1e    <= r_d1d;
            r_off2   <= n_off2;
            r_sens2  <= n_sens2;
            r_temp2f <= r_temp2e;
            r_d1f    <= r_d1e;
        end
    end

    assign o_valid = r_vf;
    assign o_d1    = r_d1f;
    assign o_temp2 = r_temp2f;
    assign o_sens2 = r_sens2;
    assign o_off2  = r_off2;

endmodule

/* sv/pcomp_press.sv */
// Pressure stages: D1*SENS split product, scaling, divide by ten and output saturation.
module pcomp_press (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [23:0]         i_d1,
    input  logic signed [19:0]  i_temp2,
    input  logic signed [38:0]  i_sens2,
    input  logic signed [39:0]  i_off2,
    output logic                o_valid,
    output logic signed [18:0]  o_temperature_centi,
    output logic [15:0]         o_pressure_mbar,
    output logic                o_clamped
);
    import pcomp_pkg::*;

    // stage G
    logic [19:0]        w_slo;
    logic signed [18:0] w_shi;
    logic [43:0]        n_pl, r_pl;
    logic signed [42:0] n_ph, r_ph;
    logic signed [39:0] r_off2g;
    logic signed [19:0] r_temp2g;
    logic               r_vg;

    // stage H
    logic signed [62:0] n_prod, r_prod;
    logic signed [39:0] r_off2h;
    logic signed [19:0] r_temp2h;
    logic               r_vh;

    // stage I
    logic signed [42:0] n_x, r_x;
    logic               w_round;
    logic signed [19:0] r_temp2i;
    logic               r_vi;

    // stage J
    logic               n_neg, n_hi;
    logic [19:0]        n_qn, r_qn;
    logic               r_neg, r_hi;
    logic signed [19:0] r_temp2j;
    logic               r_vj;

    // stage K (output)
    logic [39:0]        w_m;
    logic               w_tmax, w_tmin;
    logic signed [18:0] n_temp_out, r_temp_out;
    logic [15:0]        n_pres_out, r_pres_out;
    logic               n_clamp, r_clamp;
    logic               r_vk;

    assign w_slo = i_sens2[19:0];
    assign w_shi = i_sens2[38:20];
    assign n_pl  = 44'(i_d1 * w_slo);
    assign n_ph  = 43'($signed({1'b0, i_d1}) * w_shi);

    assign n_prod = $signed({r_ph, 20'b0}) + $signed({19'b0, r_pl});

    // truncating /2^21, then subtract OFF
    assign w_round = r_prod[62] && (r_prod[20:0] != '0);
    assign n_x     = 43'($signed(r_prod[62:21])) - 43'(r_off2h) +
                     43'($signed({1'b0, w_round}));

    assign n_neg = r_x <= X_NEG_LIM;
    assign n_hi  = r_x >= X_POS_LIM;
    assign n_qn  = (r_x[42] || n_hi) ? '0 : r_x[32:13];

    assign w_m        = 40'(r_qn * DIV10_MUL);
    assign w_tmax     = r_temp2j > TEMP_OUT_MAX;
    assign w_tmin     = r_temp2j < TEMP_OUT_MIN;
    assign n_temp_out = w_tmax ? TEMP_OUT_MAX[18:0] :
                        w_tmin ? TEMP_OUT_MIN[18:0] : r_temp2j[18:0];
    assign n_pres_out = r_hi ? 16'hFFFF : (r_neg ? 16'h0000 : w_m[38:23]);
    assign n_clamp    = w_tmax || w_tmin || r_hi || r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg <= 1'b0;
            r_vh <= 1'b0;
            r_vi <= 1'b0;
            r_vj <= 1'b0;
            r_vk <= 1'b0;
        end else if (i_en) begin
            r_vg <= i_valid;
            r_vh <= r_vg;
            r_vi <= r_vh;
            r_vj <= r_vi;
            r_vk <= r_vj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl       <= n_pl;
            r_ph       <= n_ph;
            r_off2g    <= i_off2;
            r_temp2g   <= i_temp2;
            r_prod     <= n_prod;
            r_off2h    <= r_off2g;
            r_temp2h   <= r_temp2g;
            r_x        <= n_x;
            r_temp2i   <= r_temp2h;
            r_qn       <= n_qn;
            r_neg      <= n_neg;
            r_hi       <= n_hi;
            r_temp2j   <= r_temp2i;
            r_temp_out <= n_temp_out;
            r_pres_out <= n_pres_out;
            r_clamp    <= n_clamp;
        end
    end

    assign o_valid             = r_vk;
    assign o_temperature_centi = r_temp_out;
    assign o_pressure_mbar     = r_pres_out;
    assign o_clamped           = r_clamp;

endmodule

/* sv/pressure_sensor_compensation.sv */
// Top level: calibration registers, pipeline flow control and stage instances.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one word per cycle while o_stall
//   is low: the raw D1 pressure and D2 temperature conversions. Output channel
//   (o_valid / i_stall) delivers compensated temperature (0.01 degC), pressure
//   (mbar) and a clamp flag, one word per input word, in order.
//   Calibration words C1..C6 are written through the cfg port at index 0..5
//   (o_cfg_ready is always high); indexes 6 and 7 are ignored. Write them
//   only while the pipeline is empty.
//   Eleven register stages (dT, products, first-order terms, squares,
//   second-order terms, corrected terms, split D1*SENS multiply, product
//   sum, OFF subtract, range check, divide by ten). Throughput is one word
//   per cycle while i_stall does not hold an output word, as every stage
//   takes a new word each cycle that the pipeline is enabled.
//   The whole pipeline advances as one; when the output word is held by
//   i_stall, every stage freezes and o_stall is raised the same cycle, so
//   no word is dropped or repeated.
//   Synchronous reset clears all valid bits and sets calibration words to 0.
module pressure_sensor_compensation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [23:0]         i_raw_pressure,
    input  logic [23:0]         i_raw_temperature,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [18:0]  o_temperature_centi,
    output logic [15:0]         o_pressure_mbar,
    output logic                o_clamped,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import pcomp_pkg::*;

    t_cal               r_cal;
    logic               w_en;

    logic               w_v1, w_v2;
    logic [23:0]        w_d1_1, w_d1_2;
    logic signed [18:0] w_temp1;
    logic signed [17:0] w_tq;
    logic signed [33:0] w_sens1;
    logic signed [34:0] w_off1;
    logic [16:0]        w_ti_lo;
    logic [11:0]        w_ti_hi;
    logic signed [19:0] w_temp2;
    logic signed [38:0] w_sens2;
    logic signed [39:0] w_off2;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PRESSURE_SENS:   r_cal.c1 <= i_cfg_data;
                REG_PRESSURE_OFFSET: r_cal.c2 <= i_cfg_data;
                REG_SENS_TEMP_COEFF: r_cal.c3 <= i_cfg_data;
                REG_OFFS_TEMP_COEFF: r_cal.c4 <= i_cfg_data;
                REG_REF_TEMP:        r_cal.c5 <= i_cfg_data;
                REG_TEMP_SLOPE:      r_cal.c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pcomp_first u_first (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (i_valid),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cal             (r_cal),
        .o_valid           (w_v1),
        .o_d1              (w_d1_1),
        .o_temp1           (w_temp1),
        .o_tq              (w_tq),
        .o_sens1           (w_sens1),
        .o_off1            (w_off1),
        .o_ti_lo           (w_ti_lo),
        .o_ti_hi           (w_ti_hi)
    );

    pcomp_second u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_d1    (w_d1_1),
        .i_temp1 (w_temp1),
        .i_tq    (w_tq),
        .i_sens1 (w_sens1),
        .i_off1  (w_off1),
        .i_ti_lo (w_ti_lo),
        .i_ti_hi (w_ti_hi),
        .o_valid (w_v2),
        .o_d1    (w_d1_2),
        .o_temp2 (w_temp2),
        .o_sens2 (w_sens2),
        .o_off2  (w_off2)
    );

    pcomp_press u_press (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (w_en),
        .i_valid             (w_v2),
        .i_d1                (w_d1_2),
        .i_temp2             (w_temp2),
        .i_sens2             (w_sens2),
        .i_off2              (w_off2),
        .o_valid             (o_valid),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_mbar     (o_pressure_mbar),
        .o_clamped           (o_clamped)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_clamp_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamped) |->
            (o_pressure_mbar == 16'hFFFF || o_pressure_mbar == 16'h0000 ||
             o_temperature_centi == TEMP_OUT_MAX[18:0] ||
             o_temperature_centi == TEMP_OUT_MIN[18:0]))
        else $error("clamp flag without a saturated field");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == REG_REF_TEMP) |=>
            (r_cal.c5 == $past(i_cfg_data)))
        else $error("calibration write lost");

endmodule

/* dv/pressure_sensor_compensation_test.sv */
// Self-checking testbench for pressure_sensor_compensation: predicts every reading from the raw pair and calibration.
module pressure_sensor_compensation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pcomp_pkg::*;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 100;

    localparam longint TI_LOW_DIV  = 64'sd8589934592;
    localparam longint TI_HIGH_DIV = 64'sd137438953472;

    localparam t_cal DATASHEET_CAL =
        {16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
    // C5 * 256 = 0x800000 and C6 = 2^15 put TEMP at 2000 + dT / 256
    localparam t_cal BOUNDARY_CAL =
        {16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd32768, 16'd32768};
    localparam t_cal MIXED_CAL_A =
        {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
    localparam t_cal MIXED_CAL_B =
        {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};

    typedef enum logic [1:0] {BAND_HIGH, BAND_LOW, BAND_VERY_LOW} t_band;

    typedef struct packed {
        logic signed [18:0] temperature_centi;
        logic [15:0]        pressure_mbar;
        logic               clamped;
        t_band              band;
    } t_reading;

    typedef struct packed {
        logic [23:0] d1;
        logic [23:0] d2;
    } t_raw_pair;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [23:0]        i_raw_pressure = '0;
    logic [23:0]        i_raw_temperature = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [18:0] o_temperature_centi;
    logic [15:0]        o_pressure_mbar;
    logic               o_clamped;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    t_raw_pair   raw_pairs_pending[$];
    t_reading    expected_readings[$];
    t_cal        cal_now = '0;

    bit          in_taken = 1'b0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_go = 1'b0;
    bit          rx_hold = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_left = 0;

    int n_errors = 0;
    int n_checked = 0;
    int n_clamped = 0;
    int n_high = 0;
    int n_low = 0;
    int n_very_low = 0;
    int n_cal_loads = 0;
    int n_cfg_writes = 0;

    pressure_sensor_compensation uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_mbar     (o_pressure_mbar),
        .o_clamped           (o_clamped),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTED) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        n_errors++;
    endtask

    // second-order compensation, signed 64-bit, truncating division
    function automatic t_reading compensate(input logic [23:0] d1_raw,
                                            input logic [23:0] d2_raw);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, sens, off, temp, ti, offi, sensi, p, t_lo, t_vl;
        t_reading r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = cal_now.c1;
        c2 = cal_now.c2;
        c3 = cal_now.c3;
        c4 = cal_now.c4;
        c5 = cal_now.c5;
        c6 = cal_now.c6;
        r.clamped = 1'b0;

        dt   = d2 - c5 * 256;
        sens = c1 * 32768 + (c3 * dt) / 256;
        off  = c2 * 65536 + (c4 * dt) / 128;
        temp = 2000 + (dt * c6) / 8388608;
        t_lo = temp - 2000;
        t_vl = temp + 1500;

        if (temp / 100 < 20) begin
            r.band = BAND_LOW;
            ti    = 3 * dt * dt / TI_LOW_DIV;
            offi  = 3 * t_lo * t_lo / 2;
            sensi = 5 * t_lo * t_lo / 8;
            if (temp / 100 < -15) begin
                r.band = BAND_VERY_LOW;
                offi  += 7 * t_vl * t_vl;
                sensi += 4 * t_vl * t_vl;
            end
        end else begin
            r.band = BAND_HIGH;
            ti    = 2 * dt * dt / TI_HIGH_DIV;
            offi  = t_lo * t_lo / 16;
            sensi = 0;
        end

        off  -= offi;
        sens -= sensi;
        temp -= ti;
        p = (((d1 * sens) / 2097152 - off) / 8192) / 10;

        if (temp > 262143) begin
            temp = 262143;
            r.clamped = 1'b1;
        end else if (temp < -262144) begin
            temp = -262144;
            r.clamped = 1'b1;
        end
        if (p > 65535) begin
            p = 65535;
            r.clamped = 1'b1;
        end else if (p < 0) begin
            p = 0;
            r.clamped = 1'b1;
        end

        r.temperature_centi = temp[18:0];
        r.pressure_mbar     = p[15:0];
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] extreme24();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h000001;
            3:       return 24'hFFFFFE;
            4:       return 24'h800000;
            default: return 24'h7FFFFF;
        endcase
    endfunction

    // D2 is often placed near C5 * 256 so that all three bands get hit
    function automatic t_raw_pair random_pair();
        t_raw_pair   w;
        longint      centre, span, v;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) w.d1 = 24'($urandom);
        else if (roll < 85) w.d1 = 24'($urandom_range(4000000, 9000000));
        else w.d1 = extreme24();

        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            w.d2 = 24'($urandom);
        end else if (roll < 80) begin
            centre = longint'(cal_now.c5) * 256;
            case ($urandom_range(0, 2))
                0:       span = 512;
                1:       span = 65536;
                default: span = 2097152;
            endcase
            v = centre - span + longint'($urandom_range(0, 32'(2 * span)));
            if (v < 0) v = 0;
            if (v > 16777215) v = 16777215;
            w.d2 = v[23:0];
        end else begin
            w.d2 = extreme24();
        end
        return w;
    endfunction

    function automatic t_cal random_cal(input bit near_typical);
        t_cal c;
        int   w;
        for (int k = 0; k < 6; k++) begin
            if (near_typical) begin
                w = int'(DATASHEET_CAL[16 * k +: 16]) + int'($urandom_range(0, 8191)) - 4096;
                c[16 * k +: 16] = w[15:0];
            end else begin
                c[16 * k +: 16] = 16'($urandom_range(0, 65535));
            end
        end
        return c;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_PRESSURE_SENS:   cal_now.c1 = val;
            REG_PRESSURE_OFFSET: cal_now.c2 = val;
            REG_SENS_TEMP_COEFF: cal_now.c3 = val;
            REG_OFFS_TEMP_COEFF: cal_now.c4 = val;
            REG_REF_TEMP:        cal_now.c5 = val;
            REG_TEMP_SLOPE:      cal_now.c6 = val;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    // spare indexes go last so an aliased decode would overwrite a real word
    task automatic load_cal(input t_cal cal);
        for (int k = REG_PRESSURE_SENS; k <= REG_TEMP_SLOPE; k++) begin
            cfg_write(3'(k), cal[16 * (REG_TEMP_SLOPE - k) +: 16]);
        end
        cfg_write(CFG_SPARE_LO, 16'($urandom));
        cfg_write(CFG_SPARE_HI, 16'($urandom));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cal_loads++;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (raw_pairs_pending.size() != 0 || i_valid || expected_readings.size() != 0);
    endtask

    task automatic run_random_phase(input t_cal cal, input int n_pairs);
        drain();
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        load_cal(cal);
        repeat (n_pairs) raw_pairs_pending.push_back(random_pair());
    endtask

    // input side
    always @(negedge i_clk) begin
        t_raw_pair next_pair;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (tx_wait > 0) begin
                tx_wait--;
                i_valid <= 1'b0;
            end else if (raw_pairs_pending.size() != 0) begin
                next_pair = raw_pairs_pending.pop_front();
                i_valid           <= 1'b1;
                i_raw_pressure    <= next_pair.d1;
                i_raw_temperature <= next_pair.d2;
                tx_wait = tx_idle_on ? idle_len() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side stall pattern
    always @(negedge i_clk) begin
        int unsigned len;
        if (rx_hold) begin
            i_stall <= 1'b1;
        end else if (!i_rst_n || !rx_idle_on) begin
            i_stall <= 1'b0;
        end else if (rx_left > 0) begin
            rx_left--;
        end else begin
            len = idle_len();
            if (len == 0) begin
                i_stall <= 1'b0;
                rx_left = $urandom_range(0, 6);
            end else begin
                i_stall <= 1'b1;
                rx_left = len - 1;
            end
        end
    end

    // long output hold-off while the sender keeps offering words
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // check the output word first, then record the accepted input word
    always @(posedge i_clk) begin
        t_reading want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected word T=%0d P=%0d clamp=%0b",
                    o_temperature_centi, o_pressure_mbar, o_clamped));
            end else begin
                want = expected_readings.pop_front();
                if (o_temperature_centi !== want.temperature_centi) begin
                    report_mismatch($sformatf("word %0d temperature %0d, expected %0d",
                        n_checked, o_temperature_centi, want.temperature_centi));
                end
                if (o_pressure_mbar !== want.pressure_mbar) begin
                    report_mismatch($sformatf("word %0d pressure %0d, expected %0d",
                        n_checked, o_pressure_mbar, want.pressure_mbar));
                end
                if (o_clamped !== want.clamped) begin
                    report_mismatch($sformatf("word %0d clamp flag %b, expected %b",
                        n_checked, o_clamped, want.clamped));
                end
                n_checked++;
            end
        end
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            got = compensate(i_raw_pressure, i_raw_temperature);
            expected_readings.push_back(got);
            case (got.band)
                BAND_HIGH: n_high++;
                BAND_LOW:  n_low++;
                default:   n_very_low++;
            endcase
            if (got.clamped) n_clamped++;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // calibration words still at their reset value
        raw_pairs_pending.push_back({24'd0, 24'd0});
        raw_pairs_pending.push_back({24'hFFFFFF, 24'hFFFFFF});
        raw_pairs_pending.push_back({24'd6465444, 24'd8077636});

        // band boundaries: TEMP 2000, 1999, -1599, -1600 and far out
        drain();
        load_cal(BOUNDARY_CAL);
        raw_pairs_pending.push_back({24'd6465444, 24'h800000});
        raw_pairs_pending.push_back({24'd6465444, 24'h7FFF00});
        raw_pairs_pending.push_back({24'd6465444, 24'h7FFF01});
        raw_pairs_pending.push_back({24'd6465444, 24'h800000 - 24'd921344});
        raw_pairs_pending.push_back({24'd6465444, 24'h800000 - 24'd921600});
        raw_pairs_pending.push_back({24'h555555, 24'h800000 - 24'd921601});
        raw_pairs_pending.push_back({24'd0, 24'd0});
        raw_pairs_pending.push_back({24'hFFFFFF, 24'hFFFFFF});
        raw_pairs_pending.push_back({24'd0, 24'hFFFFFF});
        raw_pairs_pending.push_back({24'hFFFFFF, 24'd0});
        raw_pairs_pending.push_back({24'hAAAAAA, 24'h555555});
        raw_pairs_pending.push_back({24'h555555, 24'hAAAAAA});
        raw_pairs_pending.push_back({24'h000001, 24'h800001});
        raw_pairs_pending.push_back({24'hFFFFFE, 24'h7FFFFF});

        // typical part, in range and saturating both ways
        drain();
        load_cal(DATASHEET_CAL);
        raw_pairs_pending.push_back({24'd6465444, 24'd8077636});
        raw_pairs_pending.push_back({24'd4958179, 24'd6815414});
        raw_pairs_pending.push_back({24'hFFFFFF, 24'd8077636});
        raw_pairs_pending.push_back({24'd0, 24'd8077636});

        run_random_phase('1, 60);
        run_random_phase('0, 40);
        run_random_phase(MIXED_CAL_A, 30);
        run_random_phase(MIXED_CAL_B, 30);
        for (int ph = 0; ph < 7; ph++) begin
            run_random_phase(random_cal(ph % 3 != 2), 100);
        end

        drain();
        load_cal(random_cal(1'b1));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        repeat (190) raw_pairs_pending.push_back(random_pair());
        hold_go = 1'b1;

        drain();
        repeat (24) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
        end

        $display("Checked %0d readings across %0d calibration loads (%0d register writes).",
            n_checked, n_cal_loads, n_cfg_writes);
        $display("Bands high/low/very low %0d/%0d/%0d, %0d saturated, %0d-cycle output hold-off.",
            n_high, n_low, n_very_low, n_clamped, RX_HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("** pressure_sensor_compensation: PASSED **");
        end else begin
            $display("** pressure_sensor_compensation: FAILED **");
        end
        $finish;
    end

    initial begin
        #18_000_000;
        $display("Timeout: %0d readings still pending", expected_readings.size());
        $display("** pressure_sensor_compensation: FAILED **");
        $finish;
    end

endmodule
